/* hw/rtl/trcd_pkg.sv */
// trcd_pkg: shared types, codes and constants of the descriptor ring
// word formats of the request and result channels and the front-to-back command
// no dependencies
package trcd_pkg;

    localparam int MAX_DEPTH   = 64;
    localparam int CHUNK_SHIFT = 28;
    localparam int QUEUE_DEPTH = 2;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 64;
    localparam int SIZE_W    = 40;
    localparam int HANDLE_W  = 32;
    localparam int OPC_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int DEPTH_W   = 7;
    localparam int IDX_W     = 6;
    localparam int LEN_W     = 29;
    localparam int CHUNKS_W  = SIZE_W - CHUNK_SHIFT + 1;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_V = DEPTH_W'(2);
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_V = DEPTH_W'(MAX_DEPTH);
    localparam logic [DEPTH_W-1:0] RESET_DEPTH = DEPTH_W'(64);
    localparam logic [LEN_W-1:0]   CHUNK_LEN   = LEN_W'(1) << CHUNK_SHIFT;
    localparam logic [ADDR_W-1:0]  CHUNK_STEP  = ADDR_W'(1) << CHUNK_SHIFT;

    localparam logic [OP_W-1:0] OP_POST     = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    localparam logic [PADDR_W-1:0] REG_RING_DEPTH = 3'd0;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [ADDR_W-1:0]   source_address;
        logic [ADDR_W-1:0]   dest_address;
        logic [SIZE_W-1:0]   transfer_size;
        logic [HANDLE_W-1:0] source_segment;
        logic [HANDLE_W-1:0] dest_segment;
        logic [HANDLE_W-1:0] target_handle;
        logic [OPC_W-1:0]    transfer_opcode;
        logic                completion_ok;
    } req_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DEPTH_W-1:0]  chunk_count;
        logic [IDX_W-1:0]    slot_index;
        logic [ADDR_W-1:0]   chunk_source;
        logic [ADDR_W-1:0]   chunk_dest;
        logic [LEN_W-1:0]    chunk_length;
        logic [HANDLE_W-1:0] out_source_segment;
        logic [HANDLE_W-1:0] out_dest_segment;
        logic [HANDLE_W-1:0] out_target_handle;
        logic [OPC_W-1:0]    out_opcode;
        logic                last;
    } rsp_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DEPTH_W-1:0]  chunk_count;
        logic [DEPTH_W-1:0]  remaining;
        logic [DEPTH_W-1:0]  depth;
        logic [IDX_W-1:0]    slot;
        logic [ADDR_W-1:0]   source;
        logic [ADDR_W-1:0]   dest;
        logic [LEN_W-1:0]    last_len;
        logic [HANDLE_W-1:0] source_segment;
        logic [HANDLE_W-1:0] dest_segment;
        logic [HANDLE_W-1:0] target_handle;
        logic [OPC_W-1:0]    opcode;
    } cmd_t;

endpackage

/* hw/rtl/trcd_front.sv */
// trcd_front: accepts request words, keeps ring indices and depth register
// classifies each word and turns all but OP_NONE words into back-end commands; depends on trcd_pkg
module trcd_front
    import trcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_word_t            req_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic [DEPTH_W-1:0]  ring_depth_reg;
    logic [IDX_W-1:0]    post_index_reg, post_index_next;
    logic [IDX_W-1:0]    ack_index_reg, ack_index_next;
    logic [DEPTH_W-1:0]  depth_eff;
    logic [DEPTH_W-1:0]  occ;
    logic [DEPTH_W-1:0]  free_slots;
    logic [CHUNKS_W-1:0] chunks;
    logic [DEPTH_W-1:0]  post_sum;
    logic [DEPTH_W-1:0]  ack_inc;
    logic                accept;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_RING_DEPTH[PADDR_W-1:2];
    assign prdata    = (paddr[PADDR_W-1:2] == REG_RING_DEPTH[PADDR_W-1:2])
                       ? PDATA_W'(ring_depth_reg) : '0;

    assign req_stall = q_full;
    assign accept    = req_valid && !req_stall;
    assign q_push    = accept && req_word.operation != OP_NONE;

    always_comb
    begin
        if (ring_depth_reg < MIN_DEPTH_V)
            depth_eff = MIN_DEPTH_V;
        else if (ring_depth_reg > MAX_DEPTH_V)
            depth_eff = MAX_DEPTH_V;
        else
            depth_eff = ring_depth_reg;
    end

    always_comb
    begin
        if (post_index_reg >= ack_index_reg)
            occ = {1'b0, post_index_reg} - {1'b0, ack_index_reg};
        else
            occ = {1'b0, post_index_reg} + depth_eff - {1'b0, ack_index_reg};
    end

    assign free_slots = depth_eff - occ - DEPTH_W'(1);
    assign chunks     = CHUNKS_W'(req_word.transfer_size[SIZE_W-1:CHUNK_SHIFT])
                        + CHUNKS_W'(|req_word.transfer_size[CHUNK_SHIFT-1:0]);
    assign post_sum   = {1'b0, post_index_reg} + chunks[DEPTH_W-1:0];
    assign ack_inc    = {1'b0, ack_index_reg} + DEPTH_W'(1);

    always_comb
    begin
        q_cmd           = '0;
        q_cmd.depth     = depth_eff;
        q_cmd.remaining = DEPTH_W'(1);
        q_cmd.status    = ST_OK;
        post_index_next = post_index_reg;
        ack_index_next  = ack_index_reg;
        case (req_word.operation)
            OP_POST:
            begin
                if (chunks > CHUNKS_W'(depth_eff))
                    q_cmd.status = ST_TOO_MANY;
                else if (chunks > CHUNKS_W'(free_slots))
                    q_cmd.status = ST_BUSY;
                else if (chunks != '0)
                begin
                    q_cmd.chunk_count    = chunks[DEPTH_W-1:0];
                    q_cmd.remaining      = chunks[DEPTH_W-1:0];
                    q_cmd.slot           = post_index_reg;
                    q_cmd.source         = req_word.source_address;
                    q_cmd.dest           = req_word.dest_address;
                    q_cmd.last_len       = (req_word.transfer_size[CHUNK_SHIFT-1:0] == '0)
                                           ? CHUNK_LEN
                                           : LEN_W'(req_word.transfer_size[CHUNK_SHIFT-1:0]);
                    q_cmd.source_segment = req_word.source_segment;
                    q_cmd.dest_segment   = req_word.dest_segment;
                    q_cmd.target_handle  = req_word.target_handle;
                    q_cmd.opcode         = req_word.transfer_opcode;
                    post_index_next      = (post_sum >= depth_eff)
                                           ? IDX_W'(post_sum - depth_eff)
                                           : post_sum[IDX_W-1:0];
                end
            end
            OP_COMPLETE:
            begin
                if (occ == '0)
                    q_cmd.status = ST_EMPTY;
                else
                begin
                    q_cmd.status   = req_word.completion_ok ? ST_OK : ST_FAILED;
                    q_cmd.slot     = ack_index_reg;
                    ack_index_next = (ack_inc == depth_eff) ? '0 : ack_inc[IDX_W-1:0];
                end
            end
            OP_RELEASE:
            begin
                post_index_next = '0;
                ack_index_next  = '0;
            end
            default:
            begin
                q_cmd.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_depth_reg <= RESET_DEPTH;
            post_index_reg <= '0;
            ack_index_reg  <= '0;
        end
        else if (cfg_write)
        begin
            ring_depth_reg <= pwdata[DEPTH_W-1:0];
            post_index_reg <= '0;
            ack_index_reg  <= '0;
        end
        else if (accept)
        begin
            post_index_reg <= post_index_next;
            ack_index_reg  <= ack_index_next;
        end
    end

    // indices stay inside the ring in use
    a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, post_index_reg} < depth_eff) && ({1'b0, ack_index_reg} < depth_eff))
        else $error("ring index beyond depth");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (post_index_reg == '0) && (ack_index_reg == '0))
        else $error("depth write did not clear indices");

endmodule

/* hw/rtl/trcd_queue.sv */
// trcd_queue: short command queue between front and back end
// register array with read and write pointers; depends on trcd_pkg
module trcd_queue
    import trcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t pop_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign avail   = count_reg != '0;
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue overflow");

endmodule

/* hw/rtl/trcd_back.sv */
// trcd_back: expands queued commands into result words, one per unstalled cycle
// walks slots and chunk addresses, holds the output register; depends on trcd_pkg
module trcd_back
    import trcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_avail,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    logic             active_reg;
    cmd_t             cmd_reg;
    logic             rsp_valid_reg;
    rsp_word_t        rsp_reg;
    logic             emit;
    logic             final_chunk;
    logic [DEPTH_W-1:0] slot_inc;
    rsp_word_t        rsp_next;

    assign q_pop       = q_avail && !active_reg;
    assign emit        = active_reg && (!rsp_valid_reg || !rsp_stall);
    assign final_chunk = cmd_reg.remaining == DEPTH_W'(1);
    assign slot_inc    = {1'b0, cmd_reg.slot} + DEPTH_W'(1);
    assign rsp_valid   = rsp_valid_reg;
    assign rsp_word    = rsp_reg;

    always_comb
    begin
        rsp_next.status             = cmd_reg.status;
        rsp_next.chunk_count        = cmd_reg.chunk_count;
        rsp_next.slot_index         = cmd_reg.slot;
        rsp_next.chunk_source       = cmd_reg.source;
        rsp_next.chunk_dest         = cmd_reg.dest;
        rsp_next.chunk_length       = final_chunk ? cmd_reg.last_len : CHUNK_LEN;
        rsp_next.out_source_segment = cmd_reg.source_segment;
        rsp_next.out_dest_segment   = cmd_reg.dest_segment;
        rsp_next.out_target_handle  = cmd_reg.target_handle;
        rsp_next.out_opcode         = cmd_reg.opcode;
        rsp_next.last               = final_chunk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                active_reg <= 1'b1;
            else if (emit && final_chunk)
                active_reg <= 1'b0;
            if (emit)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_cmd;
        else if (emit)
        begin
            cmd_reg.remaining <= cmd_reg.remaining - DEPTH_W'(1);
            cmd_reg.slot      <= (slot_inc == cmd_reg.depth) ? '0 : slot_inc[IDX_W-1:0];
            cmd_reg.source    <= cmd_reg.source + CHUNK_STEP;
            cmd_reg.dest      <= cmd_reg.dest + CHUNK_STEP;
        end
        if (emit)
            rsp_reg <= rsp_next;
    end

    a_active_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> cmd_reg.remaining != '0)
        else $error("active command with no chunks left");

    // a burst runs without gaps once its word is taken
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.last && !rsp_stall) |=> rsp_valid_reg)
        else $error("gap inside descriptor burst");

endmodule

/* hw/rtl/transfer_chunking_descriptor_ring_top.sv */
// transfer_chunking_descriptor_ring_top: descriptor ring with transfer splitting
// ties front end, command queue and back end; depends on trcd_pkg and trcd_* modules
//
//   channel   direction  handshake                     payload
//   req       in         req_valid / req_stall         req_word (req_word_t)
//   rsp       out        rsp_valid / rsp_stall         rsp_word (rsp_word_t)
//   apb       in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// front end takes one request word a cycle while the two-entry command queue has room
// back end loads a command into its register, then emits one result word per cycle
// unless rsp_stall holds the output; it pops the next command only after the last word
// an OP_NONE word is dropped by the front end in its accept cycle
// reset clears both ring indices and sets the depth register to 64
// rsp_stall holds the output register; the queue then fills and raises req_stall
module transfer_chunking_descriptor_ring_top
    import trcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_word_t          req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_word_t          rsp_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic q_full;
    logic q_push;
    cmd_t push_cmd;
    logic q_pop;
    logic q_avail;
    cmd_t pop_cmd;

    trcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    trcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .pop_cmd  (pop_cmd)
    );

    trcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_avail   (q_avail),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

/* sim/transfer_chunking_descriptor_ring_top_tb.sv */
`timescale 1ns / 1ps
// testbench for transfer_chunking_descriptor_ring_top: directed, register, random and
// back-pressure tests against an in-bench prediction of the descriptor words
// depends on trcd_pkg and the rtl of transfer_chunking_descriptor_ring_top
module transfer_chunking_descriptor_ring_top_tb;
    import trcd_pkg::*;

    localparam longint unsigned CHUNK_BYTES = 64'd1 << CHUNK_SHIFT;
    localparam int unsigned     CHUNK_MAX_U = 32'd1 << CHUNK_SHIFT;
    localparam logic [PADDR_W-1:0] UNUSED_ADDR = 3'd4;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_PRINTS    = 40;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    req_word_t          req_word;
    logic               rsp_valid;
    logic               rsp_stall;
    rsp_word_t          rsp_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // predicted ring state
    logic [DEPTH_W-1:0] depth_reg;
    int                 post_slot;
    int                 ack_slot;
    rsp_word_t          expected_words[$];

    int        mismatches;
    int        words_sent;
    int        words_received;
    int        reg_writes;
    int        status_seen [5];
    int        idle_cycles;
    int        hold_request;
    int        hold_left;
    bit        idle_on;
    rsp_word_t want;

    transfer_chunking_descriptor_ring_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int active_depth();
        if (depth_reg < MIN_DEPTH_V)
            return MIN_DEPTH_V;
        if (depth_reg > MAX_DEPTH_V)
            return MAX_DEPTH_V;
        return depth_reg;
    endfunction

    function automatic void predict_descriptors(input req_word_t w);
        rsp_word_t       r;
        int              depth;
        int              occupied;
        longint unsigned size;
        longint unsigned chunks;
        longint unsigned offset;
        longint unsigned remaining;
        depth = active_depth();
        occupied = (post_slot + depth - ack_slot) % depth;
        size = {24'd0, w.transfer_size};
        r = '0;
        r.last = 1'b1;
        case (w.operation)
            OP_POST:
            begin
                chunks = (size + CHUNK_BYTES - 1) >> CHUNK_SHIFT;
                if (chunks > depth)
                begin
                    r.status = ST_TOO_MANY;
                    expected_words.push_back(r);
                end
                else if (chunks > depth - occupied - 1)
                begin
                    r.status = ST_BUSY;
                    expected_words.push_back(r);
                end
                else if (chunks == 0)
                begin
                    r.status = ST_OK;
                    expected_words.push_back(r);
                end
                else
                begin
                    for (longint unsigned i = 0; i < chunks; i++)
                    begin
                        offset = i << CHUNK_SHIFT;
                        remaining = size - offset;
                        r.status = ST_OK;
                        r.chunk_count = DEPTH_W'(chunks);
                        r.slot_index = IDX_W'((post_slot + i) % depth);
                        r.chunk_source = w.source_address + offset;
                        r.chunk_dest = w.dest_address + offset;
                        r.chunk_length = LEN_W'(remaining < CHUNK_BYTES ? remaining : CHUNK_BYTES);
                        r.out_source_segment = w.source_segment;
                        r.out_dest_segment = w.dest_segment;
                        r.out_target_handle = w.target_handle;
                        r.out_opcode = w.transfer_opcode;
                        r.last = (i + 1 == chunks);
                        expected_words.push_back(r);
                    end
                    post_slot = int'((post_slot + chunks) % depth);
                end
            end
            OP_COMPLETE:
            begin
                if (occupied == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.slot_index = IDX_W'(ack_slot);
                    r.status = w.completion_ok ? ST_OK : ST_FAILED;
                    ack_slot = (ack_slot + 1) % depth;
                end
                expected_words.push_back(r);
            end
            OP_RELEASE:
            begin
                post_slot = 0;
                ack_slot = 0;
                r.status = ST_OK;
                expected_words.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic req_word_t rand_word(input logic [OP_W-1:0] op);
        req_word_t w;
        w.operation = op;
        w.source_address = {$urandom, $urandom};
        w.dest_address = {$urandom, $urandom};
        // start near the top so that later chunks wrap
        if ($urandom_range(7) == 0)
            w.source_address = {36'hF_FFFF_FFFF, 28'($urandom)};
        if ($urandom_range(7) == 0)
            w.dest_address = {36'hF_FFFF_FFFF, 28'($urandom)};
        w.transfer_size = SIZE_W'({$urandom, $urandom});
        w.source_segment = $urandom;
        w.dest_segment = $urandom;
        w.target_handle = $urandom;
        w.transfer_opcode = OPC_W'($urandom_range(255));
        w.completion_ok = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic logic [SIZE_W-1:0] size_for(input int chunks);
        logic [SIZE_W-1:0] base;
        if (chunks <= 0)
            return '0;
        base = SIZE_W'(chunks - 1) << CHUNK_SHIFT;
        if ($urandom_range(3) == 0)
            return base + SIZE_W'(CHUNK_BYTES);
        return base + SIZE_W'($urandom_range(CHUNK_MAX_U, 1));
    endfunction

    task automatic send_word(input req_word_t w);
        if (idle_on && $urandom_range(99) < 11)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req_word <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predict_descriptors(w);
        words_sent++;
    endtask

    task automatic send_post(input int chunks);
        req_word_t w;
        w = rand_word(OP_POST);
        w.transfer_size = size_for(chunks);
        send_word(w);
    endtask

    task automatic send_completion(input logic ok);
        req_word_t w;
        w = rand_word(OP_COMPLETE);
        w.completion_ok = ok;
        send_word(w);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_RING_DEPTH)
        begin
            depth_reg = data[DEPTH_W-1:0];
            post_slot = 0;
            ack_slot = 0;
        end
        reg_writes++;
    endtask

    task automatic set_depth(input logic [PDATA_W-1:0] value);
        settle();
        apb_write(REG_RING_DEPTH, value);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at result word %0d: %s", words_received, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = expected_words.pop_front();
                check_field("status", rsp_word.status, want.status);
                check_field("chunk_count", rsp_word.chunk_count, want.chunk_count);
                check_field("slot_index", rsp_word.slot_index, want.slot_index);
                check_field("chunk_source", rsp_word.chunk_source, want.chunk_source);
                check_field("chunk_dest", rsp_word.chunk_dest, want.chunk_dest);
                check_field("chunk_length", rsp_word.chunk_length, want.chunk_length);
                check_field("out_source_segment", rsp_word.out_source_segment,
                            want.out_source_segment);
                check_field("out_dest_segment", rsp_word.out_dest_segment,
                            want.out_dest_segment);
                check_field("out_target_handle", rsp_word.out_target_handle,
                            want.out_target_handle);
                check_field("out_opcode", rsp_word.out_opcode, want.out_opcode);
                check_field("last", rsp_word.last, want.last);
            end
            if (rsp_word.status < 5)
                status_seen[rsp_word.status]++;
            words_received++;
        end
    end

    // receiver side: random stalls, or a counted hold-off when asked
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= idle_on && ($urandom_range(99) < 11);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no handshake for %0d cycles, run stopped", idle_cycles);
        $display("== FAIL ==");
        $finish;
    end

    task automatic test_directed();
        req_word_t w;
        send_completion(1'b1);
        send_post(0);
        w = rand_word(OP_POST);
        w.transfer_size = SIZE_W'(1);
        w.source_address = '1;
        w.dest_address = '1;
        w.source_segment = '1;
        w.dest_segment = '1;
        w.target_handle = '1;
        w.transfer_opcode = '1;
        send_word(w);
        w = rand_word(OP_POST);
        w.transfer_size = SIZE_W'(CHUNK_BYTES) + SIZE_W'(1);
        w.source_address = 64'hFFFF_FFFF_F800_0000;
        w.dest_address = '0;
        w.source_segment = '0;
        w.dest_segment = '0;
        w.target_handle = '0;
        w.transfer_opcode = '0;
        send_word(w);
        w = rand_word(OP_POST);
        w.transfer_size = SIZE_W'(CHUNK_BYTES);
        send_word(w);
        w = rand_word(OP_POST);
        w.transfer_size = '1;
        send_word(w);
        w = rand_word(OP_POST);
        w.transfer_size = SIZE_W'(65) << CHUNK_SHIFT;
        send_word(w);
        w.transfer_size = SIZE_W'(64) << CHUNK_SHIFT;
        send_word(w);
        send_completion(1'b1);
        send_completion(1'b0);
        send_word(rand_word(OP_NONE));
        send_word(rand_word(OP_RELEASE));
        // fill every free slot, then wrap the post index
        w = rand_word(OP_POST);
        w.transfer_size = SIZE_W'(63) << CHUNK_SHIFT;
        send_word(w);
        send_post(1);
        send_completion(1'b1);
        send_post(1);
        send_completion(1'b0);
        send_word(rand_word(OP_NONE));
        send_word(rand_word(OP_RELEASE));
    endtask

    task automatic depth_probe(input logic [PDATA_W-1:0] value);
        int d;
        set_depth(value);
        d = active_depth();
        send_post(d + 1);
        send_post(d);
        send_post(d - 1);
        send_post(1);
        send_completion(1'b1);
        send_post(1);
        repeat (3) send_completion(1'($urandom_range(1)));
        send_word(rand_word(OP_RELEASE));
    endtask

    task automatic test_depth_settings();
        depth_probe(32'd0);
        depth_probe(32'd1);
        depth_probe(32'd3);
        depth_probe(32'd127);
        depth_probe(32'd65);
        depth_probe(32'hFFFF_FF85);
        // a write to an unused address leaves depth and indices alone
        set_depth(32'd5);
        send_post(2);
        settle();
        apb_write(UNUSED_ADDR, 32'hFFFF_FFFF);
        send_post(2);
        send_post(1);
        send_completion(1'b1);
    endtask

    task automatic run_random(input int count);
        req_word_t w;
        int        pick;
        int        k;
        int        d;
        d = active_depth();
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                w = rand_word(OP_POST);
                pick = $urandom_range(99);
                if (pick < 70)
                    k = $urandom_range(3, 1);
                else if (pick < 86)
                    k = $urandom_range(d, 1);
                else if (pick < 93)
                    k = $urandom_range(d + 2, d);
                else
                    k = 0;
                w.transfer_size = size_for(k);
                if ($urandom_range(19) == 0)
                    w.transfer_size = SIZE_W'({$urandom, $urandom});
                send_word(w);
            end
            else if (pick < 88)
                send_word(rand_word(OP_COMPLETE));
            else if (pick < 93)
                send_word(rand_word(OP_RELEASE));
            else if (pick < 95)
                send_word(rand_word(OP_NONE));
            else
                send_completion(1'b0);
        end
    endtask

    task automatic test_random();
        set_depth(32'd64);
        run_random(60);
        set_depth(32'd2);
        idle_on = 1'b0;
        run_random(60);
        idle_on = 1'b1;
        set_depth(32'd7);
        run_random(60);
        set_depth($urandom_range(64, 2));
        run_random(60);
    endtask

    task automatic test_backpressure();
        set_depth(32'd64);
        hold_request = HOLD_CYCLES;
        repeat (40)
        begin
            if ($urandom_range(2) == 0)
                send_completion(1'($urandom_range(1)));
            else
                send_post($urandom_range(3, 1));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        depth_reg = RESET_DEPTH;
        post_slot = 0;
        ack_slot = 0;
        idle_on = 1'b1;
        hold_request = 0;
        hold_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_depth_settings();
        test_random();
        test_backpressure();
        settle();

        $display("sent %0d request words, checked %0d result words, %0d register writes",
                 words_sent, words_received, reg_writes);
        $display("status seen: ok %0d, too many %0d, busy %0d, failed %0d, empty %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
